[sv/rgb2hsv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_pkg
// Shared types, constants and the divider step for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

    // hue sector offsets and full circle, in 1/64 degree
    localparam logic [14:0] HUE_SEC_G = 15'd7680;
    localparam logic [14:0] HUE_SEC_B = 15'd15360;
    localparam logic [14:0] HUE_FULL  = 15'd23040;

    // divider geometry: hue quotient is at most 3840, saturation at most 255
    localparam int HUE_QW = 12;
    localparam int SAT_QW = 8;
    localparam int N_STEP = HUE_QW;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // which component is largest
    typedef enum logic [1:0] {
        SEC_R = 2'd0,
        SEC_G = 2'd1,
        SEC_B = 2'd2
    } t_sector;

    // classified pixel, front to back
    typedef struct packed {
        logic [7:0] mx;
        logic [7:0] delta;
        logic [7:0] mag;
        logic       neg;
        t_sector    sector;
    } t_work;

    // one stage of the divider pipeline
    typedef struct packed {
        logic [19:0] hnum;
        logic [7:0]  hrem;
        logic [11:0] hq;
        logic [15:0] snum;
        logic [7:0]  srem;
        logic [7:0]  sq;
        logic [7:0]  delta;
        logic [7:0]  mx;
        logic        neg;
        t_sector     sector;
    } t_stage;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
                                            input logic [7:0] den);
        logic [8:0] t;
        logic [8:0] d;
        t = {rem, nb};
        d = {1'b0, den};
        if (t >= d) begin
            t = t - d;
            return {1'b1, t[7:0]};
        end
        return {1'b0, t[7:0]};
    endfunction

endpackage
`default_nettype wire

[sv/rgb2hsv_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_front
// Accepts pixels and classifies them: max, delta, sector, hue difference.
// ----------------------------------------------------------------------------
module rgb2hsv_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_red,
    input  wire logic [7:0]         i_green,
    input  wire logic [7:0]         i_blue,
    output logic                    o_push,
    input  wire logic               i_full,
    output rgb2hsv_pkg::t_work      o_work
);

    logic               r_fv;
    rgb2hsv_pkg::t_work r_fw;
    rgb2hsv_pkg::t_work n_fw;
    logic               adv;
    logic [7:0]         mn;
    logic [7:0]         da;
    logic [7:0]         db;

    assign adv     = !r_fv || !i_full;
    assign o_stall = !adv;
    assign o_push  = r_fv;
    assign o_work  = r_fw;

    // max/min and sector; red wins ties, then green
    always_comb begin
        n_fw = '0;
        if (i_red >= i_green && i_red >= i_blue) begin
            n_fw.sector = rgb2hsv_pkg::SEC_R;
            n_fw.mx     = i_red;
            da          = i_green;
            db          = i_blue;
        end else if (i_green >= i_blue) begin
            n_fw.sector = rgb2hsv_pkg::SEC_G;
            n_fw.mx     = i_green;
            da          = i_blue;
            db          = i_red;
        end else begin
            n_fw.sector = rgb2hsv_pkg::SEC_B;
            n_fw.mx     = i_blue;
            da          = i_red;
            db          = i_green;
        end
        mn = i_red;
        if (i_green < mn) begin
            mn = i_green;
        end
        if (i_blue < mn) begin
            mn = i_blue;
        end
        n_fw.delta = n_fw.mx - mn;
        // signed difference as sign and magnitude
        n_fw.neg   = da < db;
        n_fw.mag   = (da < db) ? (db - da) : (da - db);
    end

    // front register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (adv) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fw <= n_fw;
        end
    end

endmodule
`default_nettype wire

[sv/rgb2hsv_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_fifo
// Short register queue that decouples the front from the divider pipeline.
// ----------------------------------------------------------------------------
module rgb2hsv_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire rgb2hsv_pkg::t_work i_work,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output rgb2hsv_pkg::t_work      o_head
);

    rgb2hsv_pkg::t_work                 r_mem [0:rgb2hsv_pkg::FIFO_DEPTH-1];
    logic [rgb2hsv_pkg::FIFO_AW-1:0]    r_wp;
    logic [rgb2hsv_pkg::FIFO_AW-1:0]    r_rp;
    logic [rgb2hsv_pkg::FIFO_CW-1:0]    r_cnt;
    logic                               do_push;
    logic                               do_pop;

    assign o_full  = (r_cnt == rgb2hsv_pkg::FIFO_CW'(rgb2hsv_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_work;
        end
    end

endmodule
`default_nettype wire

[sv/rgb2hsv_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_back
// Pipelined restoring dividers for hue and saturation, then hue assembly.
// ----------------------------------------------------------------------------
module rgb2hsv_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_empty,
    input  wire rgb2hsv_pkg::t_work i_head,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [14:0]             o_hue,
    output logic [7:0]              o_saturation,
    output logic [7:0]              o_brightness,
    output logic                    o_hue_undefined
);

    localparam int NS   = rgb2hsv_pkg::N_STEP;
    localparam int SOFF = rgb2hsv_pkg::HUE_QW - rgb2hsv_pkg::SAT_QW;

    logic                   r_sv  [0:NS];
    rgb2hsv_pkg::t_stage    r_stg [0:NS];
    rgb2hsv_pkg::t_stage    n_stg [0:NS];
    logic                   adv;
    logic                   r_ov;
    logic [14:0]            r_hue;
    logic [7:0]             r_sat;
    logic [7:0]             r_bri;
    logic                   r_und;
    logic [14:0]            n_hue;
    logic [14:0]            q15;

    // whole pipeline moves unless a result is held by the receiver
    assign adv   = !r_ov || !i_stall;
    assign o_pop = adv && !i_empty;

    // stage 0: numerators from the queue head
    always_comb begin
        n_stg[0]        = '0;
        n_stg[0].hnum   = {i_head.mag, 12'd0} - {4'd0, i_head.mag, 8'd0};
        n_stg[0].hrem   = n_stg[0].hnum[19:12];
        n_stg[0].snum   = {i_head.delta, 8'd0} - {8'd0, i_head.delta};
        n_stg[0].srem   = n_stg[0].snum[15:8];
        n_stg[0].delta  = i_head.delta;
        n_stg[0].mx     = i_head.mx;
        n_stg[0].neg    = i_head.neg;
        n_stg[0].sector = i_head.sector;
    end

    // one quotient bit per stage; saturation runs in the last stages
    for (genvar k = 1; k <= NS; k++) begin : g_step
        localparam int HB = NS - k;
        logic [8:0] hs;
        logic [8:0] ss;
        always_comb begin
            n_stg[k] = r_stg[k-1];
            hs = rgb2hsv_pkg::div_step(r_stg[k-1].hrem, r_stg[k-1].hnum[HB],
                                       r_stg[k-1].delta);
            n_stg[k].hrem = hs[7:0];
            n_stg[k].hq   = {r_stg[k-1].hq[10:0], hs[8]};
            ss = '0;
            if (k > SOFF) begin
                ss = rgb2hsv_pkg::div_step(r_stg[k-1].srem, r_stg[k-1].snum[HB],
                                           r_stg[k-1].mx);
                n_stg[k].srem = ss[7:0];
                n_stg[k].sq   = {r_stg[k-1].sq[6:0], ss[8]};
            end
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NS; i++) begin
                r_sv[i] <= 1'b0;
            end
        end else if (adv) begin
            r_sv[0] <= !i_empty;
            for (int i = 1; i <= NS; i++) begin
                r_sv[i] <= r_sv[i-1];
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i <= NS; i++) begin
                r_stg[i] <= n_stg[i];
            end
        end
    end

    // hue: sector offset plus or minus the quotient, wrapped below zero; zero when delta is zero
    always_comb begin
        q15 = {3'd0, r_stg[NS].hq};
        case (r_stg[NS].sector)
            rgb2hsv_pkg::SEC_R: n_hue = r_stg[NS].neg ? (rgb2hsv_pkg::HUE_FULL - q15) : q15;
            rgb2hsv_pkg::SEC_G: n_hue = r_stg[NS].neg ? (rgb2hsv_pkg::HUE_SEC_G - q15)
                                                      : (rgb2hsv_pkg::HUE_SEC_G + q15);
            rgb2hsv_pkg::SEC_B: n_hue = r_stg[NS].neg ? (rgb2hsv_pkg::HUE_SEC_B - q15)
                                                      : (rgb2hsv_pkg::HUE_SEC_B + q15);
            default:            n_hue = '0;
        endcase
        if (r_stg[NS].delta == '0) begin
            n_hue = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_sv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hue <= n_hue;
            r_sat <= (r_stg[NS].mx == '0) ? 8'd0 : r_stg[NS].sq;
            r_bri <= r_stg[NS].mx;
            r_und <= (r_stg[NS].mx != '0) && (r_stg[NS].delta == '0);
        end
    end

    assign o_valid         = r_ov;
    assign o_hue           = r_hue;
    assign o_saturation    = r_sat;
    assign o_brightness    = r_bri;
    assign o_hue_undefined = r_und;

endmodule
`default_nettype wire

[sv/rgb_to_hsv_convert.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// Converts one 8-bit RGB pixel to hue (1/64 degree), saturation and value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_red, i_green, i_blue. A pixel is
//   taken at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_hue, o_saturation,
//   o_brightness, o_hue_undefined. A result is taken at an edge with o_valid
//   high and i_stall low; one result per pixel, in order.
//   Throughput: one pixel per clock while o_stall is low. From acceptance to
//   o_valid a pixel passes one front register, one queue slot, the divider
//   load stage, twelve divider stages (one quotient bit each) and the output
//   register. The twelve-bit hue quotient sets the pipeline depth.
//   Receiver stall: the divider pipeline holds while a result waits; the
//   four-entry queue keeps taking pixels until full, then o_stall rises.
//   Reset (i_rst_n low, synchronous) empties the queue and the pipeline;
//   no results are pending afterwards.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [7:0]     i_red,
    input  wire logic [7:0]     i_green,
    input  wire logic [7:0]     i_blue,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [14:0]         o_hue,
    output logic [7:0]          o_saturation,
    output logic [7:0]          o_brightness,
    output logic                o_hue_undefined
);

    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    rgb2hsv_pkg::t_work fwork;
    rgb2hsv_pkg::t_work head;

    // classify pixels
    rgb2hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_push  (push),
        .i_full  (full),
        .o_work  (fwork)
    );

    // decoupling queue
    rgb2hsv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (fwork),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    // dividers and result assembly
    rgb2hsv_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hue           (o_hue),
        .o_saturation    (o_saturation),
        .o_brightness    (o_brightness),
        .o_hue_undefined (o_hue_undefined)
    );

endmodule
`default_nettype wire
